// File: hdl/pbm_pkg.sv
// Shared types and constants for the ARGB8888 pixel blend mode unit.
package pbm_pkg;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 32;
    localparam int MODE_W = 3;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_REPLACE = 3'd0;
    localparam mode_t MODE_ALPHA   = 3'd1;
    localparam mode_t MODE_ADD     = 3'd2;
    localparam mode_t MODE_OVERLAY = 3'd3;
    localparam mode_t MODE_LIGHTEN = 3'd4;

    localparam mode_t MODE_RESET = MODE_ALPHA;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Control that the top level hands to each color channel pipeline.
    typedef struct packed {
        logic  en;       // advance every stage
        mode_t mode_s2;  // mode of the request in the last channel stage
    } chan_ctrl_t;

endpackage

// File: hdl/pbm_chan.sv
// Three-stage blend datapath for one 8-bit color channel.
module pbm_chan (
    input  logic                  clk,
    input  pbm_pkg::chan_ctrl_t   ctrl,
    input  logic [7:0]            s,
    input  logic [7:0]            d,
    input  logic [7:0]            a,
    output logic [7:0]            r
);
    import pbm_pkg::*;

    // stage 1 combinational
    logic signed [8:0]  diff;
    logic signed [17:0] aprod_full;
    logic [7:0]         ovl_m0;
    logic [7:0]         ovl_m1;
    logic [15:0]        ovl_prod;

    // stage 1 registers
    logic signed [16:0] aprod_reg;
    logic [16:0]        ovl_x_reg;
    logic               ovl_hi_reg;
    logic [7:0]         s1_reg;
    logic [7:0]         d1_reg;

    // stage 2 combinational
    logic signed [8:0]  aq;
    logic [7:0]         alpha_next;
    logic [9:0]         add_t;
    logic [9:0]         add_m1;
    logic [7:0]         add_next;
    logic [7:0]         max_next;
    logic [17:0]        est_sum;

    // stage 2 registers
    logic [7:0]         alpha_reg;
    logic [7:0]         add_reg;
    logic [7:0]         max_reg;
    logic [16:0]        ovl_x2_reg;
    logic [9:0]         ovl_q0_reg;
    logic               ovl_hi2_reg;

    // stage 3 combinational
    logic [17:0]        ovl_rem;
    logic [9:0]         ovl_q;
    logic [7:0]         ovl_res;

    always_comb
    begin
        diff       = $signed({1'b0, s}) - $signed({1'b0, d});
        aprod_full = $signed({1'b0, a}) * diff;
        // upper half uses the inverted operands: 255 - x is ~x on 8 bits
        ovl_m0     = d[7] ? ~s : s;
        ovl_m1     = d[7] ? ~d : d;
        ovl_prod   = ovl_m0 * ovl_m1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            aprod_reg  <= aprod_full[16:0];
            ovl_x_reg  <= {ovl_prod, 1'b0};
            ovl_hi_reg <= d[7];
            s1_reg     <= s;
            d1_reg     <= d;
        end
    end

    always_comb
    begin
        // floor division by 256
        aq         = aprod_reg[16:8];
        alpha_next = aq[7:0] + d1_reg;

        add_t  = {2'b00, d1_reg} + {1'b0, s1_reg, 1'b0};
        add_m1 = add_t - 10'd1;
        if (add_t == 10'd0)
            add_next = 8'd0;
        else if (add_m1 > {2'b00, CH_MAX})
            add_next = CH_MAX;
        else
            add_next = add_m1[7:0];

        max_next = (s1_reg > d1_reg) ? s1_reg : d1_reg;

        // estimate x / 255, low by at most one
        est_sum = {1'b0, ovl_x_reg} + {9'd0, ovl_x_reg[16:8]} + 18'd1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            alpha_reg   <= alpha_next;
            add_reg     <= add_next;
            max_reg     <= max_next;
            ovl_x2_reg  <= ovl_x_reg;
            ovl_q0_reg  <= est_sum[17:8];
            ovl_hi2_reg <= ovl_hi_reg;
        end
    end

    always_comb
    begin
        ovl_rem = {1'b0, ovl_x2_reg} - {ovl_q0_reg, 8'd0} + {8'd0, ovl_q0_reg};
        ovl_q   = (ovl_rem >= 18'd255) ? ovl_q0_reg + 10'd1 : ovl_q0_reg;
        ovl_res = ovl_hi2_reg ? CH_MAX - ovl_q[7:0] : ovl_q[7:0];

        case (ctrl.mode_s2)
            MODE_ALPHA:   r = alpha_reg;
            MODE_ADD:     r = add_reg;
            MODE_OVERLAY: r = ovl_res;
            MODE_LIGHTEN: r = max_reg;
            default:      r = 8'd0;
        endcase
    end

endmodule

// File: hdl/pixel_blend_mode_unit_top.sv
// Top level of the ARGB8888 pixel blend mode unit.
// An accepted request passes the stage-one, stage-two and output registers in order to result valid.
// Throughput: one pixel pair per cycle; the pipeline holds as a whole while
// the output register is full and not taken.
// Reset clears all valid bits and sets the blend mode to alpha blend.
module pixel_blend_mode_unit_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  pbm_pkg::mode_t         cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            src_pixel,
    input  logic [31:0]            dest_pixel,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            result_pixel
);
    import pbm_pkg::*;

    mode_t            mode_reg;
    logic             en;
    logic             v1_reg;
    logic             v2_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] src1_reg;
    logic [PIX_W-1:0] dst1_reg;
    mode_t            mode1_reg;
    logic [PIX_W-1:0] src2_reg;
    logic [PIX_W-1:0] dst2_reg;
    mode_t            mode2_reg;
    logic [PIX_W-1:0] result_reg;
    logic [PIX_W-1:0] result_next;
    logic [PIX_W-1:0] blended;
    logic [CH_W-1:0]  alpha2;
    chan_ctrl_t       ctrl;
    logic [CH_W-1:0]  ch_res [3];

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign result_pixel = result_reg;

    assign ctrl.en      = en;
    assign ctrl.mode_s2 = mode2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_RESET;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            src1_reg   <= src_pixel;
            dst1_reg   <= dest_pixel;
            mode1_reg  <= mode_reg;
            src2_reg   <= src1_reg;
            dst2_reg   <= dst1_reg;
            mode2_reg  <= mode1_reg;
            result_reg <= result_next;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        pbm_chan u_chan (
            .clk  (clk),
            .ctrl (ctrl),
            .s    (src_pixel[c*CH_W +: CH_W]),
            .d    (dest_pixel[c*CH_W +: CH_W]),
            .a    (src_pixel[PIX_W-1 -: CH_W]),
            .r    (ch_res[c])
        );
    end

    assign alpha2  = src2_reg[PIX_W-1 -: CH_W];
    assign blended = {alpha2, ch_res[2], ch_res[1], ch_res[0]};

    always_comb
    begin
        unique case (mode2_reg) inside
            MODE_REPLACE:
                result_next = src2_reg;
            MODE_ALPHA:
            begin
                // opaque source copies, transparent source leaves destination
                if (alpha2 == CH_MAX)
                    result_next = src2_reg;
                else if (alpha2 == 8'd0)
                    result_next = dst2_reg;
                else
                    result_next = blended;
            end
            MODE_ADD, MODE_OVERLAY, MODE_LIGHTEN:
                result_next = blended;
            default:
                result_next = dst2_reg;
        endcase
    end

endmodule

// File: hdl/pbm_checker.sv
// Port-level checks for the pixel blend mode unit, bound to the top level.
module pbm_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  pbm_pkg::mode_t         cfg_wdata,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [31:0]            src_pixel,
    input  logic [31:0]            dest_pixel,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [31:0]            result_pixel
);
    import pbm_pkg::*;

    // requests taken and not yet handed out
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg + {2'b00, in_valid && in_ready}
                        - {2'b00, out_valid && out_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 3'd0;
        else
            inflight_reg <= inflight_next;
    end

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_pixel))
        else $error("stalled result changed");

    // the pipeline freezes while the output is blocked
    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while output stalled");

    // an empty output stage never blocks a request
    a_free_takes_in: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty output");

    // a result can only be offered for a request that was taken
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result appeared without request");

endmodule

bind pixel_blend_mode_unit_top pbm_checker u_pbm_checker (.*);

// File: tb/sv/pixel_blend_checker.sv
// Checker for the pixel blend unit: watches both channels, predicts each pixel and compares.
`timescale 1ns / 1ps
module pixel_blend_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  pbm_pkg::mode_t  cfg_wdata,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic [31:0]     src_pixel,
    input  logic [31:0]     dest_pixel,
    input  logic            out_valid,
    input  logic            out_ready,
    input  logic [31:0]     result_pixel,
    output int              fail_count,
    output int              pending,
    output int              results_seen
);
    import pbm_pkg::*;

    typedef struct {
        logic [31:0] pixel;
        logic [31:0] src;
        logic [31:0] dst;
        mode_t       mode;
    } blend_rec_t;

    blend_rec_t  expected_pixels[$];
    mode_t       blend_mode;

    function automatic logic [31:0] predict_blend(mode_t mode, logic [31:0] s_px,
                                                  logic [31:0] d_px);
        logic [7:0]  alpha;
        logic [31:0] px;
        int          s;
        int          d;
        int          r;
        int          k;
        alpha = s_px[31:24];
        if (mode == MODE_REPLACE)
            return s_px;
        if (mode == MODE_ALPHA && alpha == CH_MAX)
            return s_px;
        if (mode == MODE_ALPHA && alpha == 8'd0)
            return d_px;
        if (mode > MODE_LIGHTEN)
            return d_px;
        px = {alpha, 24'd0};
        for (k = 0; k < 3; k++)
        begin
            s = int'(s_px[8*k +: 8]);
            d = int'(d_px[8*k +: 8]);
            case (mode)
                MODE_ALPHA:
                begin
                    // arithmetic shift floors the signed product
                    r = ((int'(alpha) * (s - d)) >>> 8) + d;
                end
                MODE_ADD:
                begin
                    r = d + 2 * s;
                    if (r != 0)
                        r = r - 1;
                    if (r > 255)
                        r = 255;
                end
                MODE_OVERLAY:
                begin
                    if (d < 128)
                        r = (2 * s * d) / 255;
                    else
                        r = 255 - (2 * (255 - s) * (255 - d)) / 255;
                end
                default:
                    r = (s > d) ? s : d;
            endcase
            px[8*k +: 8] = r[7:0];
        end
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        blend_rec_t rec;
        if (!rst_n)
        begin
            blend_mode = MODE_RESET;
            expected_pixels.delete();
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                rec.src   = src_pixel;
                rec.dst   = dest_pixel;
                rec.mode  = blend_mode;
                rec.pixel = predict_blend(blend_mode, src_pixel, dest_pixel);
                expected_pixels.push_back(rec);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("result %08h with no request waiting",
                                              result_pixel));
                else
                begin
                    rec = expected_pixels.pop_front();
                    if (result_pixel !== rec.pixel)
                        report_mismatch($sformatf(
                            "result_pixel %08h, predicted %08h (src %08h dst %08h mode %0d)",
                            result_pixel, rec.pixel, rec.src, rec.dst, rec.mode));
                end
            end
            // a mode write lands after any request accepted on this edge
            if (cfg_we)
                blend_mode = cfg_wdata;
            pending = expected_pixels.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the pixel blend unit testbench: reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;
    import pbm_pkg::*;

    localparam mode_t MODE_UNDEF_LO  = 3'd5;
    localparam mode_t MODE_UNDEF_MID = 3'd6;
    localparam mode_t MODE_UNDEF_HI  = 3'd7;
    localparam int    BLOCK_ITEMS    = 70;
    localparam int    DRAIN_LIMIT    = 5000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    mode_t       cfg_wdata  = MODE_RESET;
    logic        in_valid   = 1'b0;
    logic [31:0] src_pixel  = '0;
    logic [31:0] dest_pixel = '0;
    logic        out_ready  = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire  [31:0] result_pixel;

    int fail_count;
    int pending;
    int results_seen;
    int send_idle_pct = 28;
    int recv_idle_pct = 46;
    int pairs_sent    = 0;

    mode_t mode_order [8] = '{MODE_ALPHA, MODE_REPLACE, MODE_LIGHTEN, MODE_ADD,
                              MODE_UNDEF_HI, MODE_OVERLAY, MODE_UNDEF_LO, MODE_UNDEF_MID};

    always #6 clk = ~clk;

    pixel_blend_mode_unit_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_pixel    (src_pixel),
        .dest_pixel   (dest_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_pixel (result_pixel)
    );

    pixel_blend_checker blend_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_pixel    (src_pixel),
        .dest_pixel   (dest_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_pixel (result_pixel),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Favor the channel values where the blend rules change behavior.
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return 8'd128;
            4:       return $urandom_range(0, 1) ? 8'd1 : 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_pixel();
        if ($urandom_range(0, 2) == 0)
            return $urandom;
        return {pick_channel(), pick_channel(), pick_channel(), pick_channel()};
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_pair(input logic [31:0] s_px, input logic [31:0] d_px);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        src_pixel  <= s_px;
        dest_pixel <= d_px;
        do
            @(posedge clk);
        while (!in_ready);
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending != 0 && n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    task automatic set_blend_mode(input mode_t m);
        wait_drain();
        repeat (3) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #2_400_000;
        $display("run exceeded its time limit with %0d results outstanding", pending);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int p;
        int b;
        int i;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // alpha blend straight out of reset: opaque, transparent, both signs of s-d
        send_pair(32'hff12_34ab, 32'h5a6b_7c8d);
        send_pair(32'h00ff_ffff, 32'h7700_80ff);
        send_pair(32'h8000_ff00, 32'h00ff_00ff);
        send_pair(32'h01ff_00ff, 32'hff00_ff00);
        send_pair(32'hfe00_ff80, 32'h00ff_007f);

        set_blend_mode(MODE_REPLACE);
        send_pair(32'hffff_ffff, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'hffff_ffff);

        // add: zero sum stays zero, clamp at the top
        set_blend_mode(MODE_ADD);
        send_pair(32'h4000_0000, 32'h0000_0001);
        send_pair(32'hffff_ff01, 32'h00ff_7f00);
        send_pair(32'h0080_0100, 32'hff00_fe00);

        // overlay: both sides of the destination threshold
        set_blend_mode(MODE_OVERLAY);
        send_pair(32'h90ff_00ff, 32'h007f_8000);
        send_pair(32'h2000_ff80, 32'hffff_7f80);
        send_pair(32'hc07f_8001, 32'h5500_ff01);

        set_blend_mode(MODE_LIGHTEN);
        send_pair(32'h1234_5678, 32'h8765_4321);
        send_pair(32'hff00_ff00, 32'h00ff_00ff);

        // undefined modes pass the destination through
        set_blend_mode(MODE_UNDEF_LO);
        send_pair(32'hffff_ffff, 32'h1357_9bdf);
        set_blend_mode(MODE_UNDEF_MID);
        send_pair(32'h0000_0000, 32'hffff_ffff);
        set_blend_mode(MODE_UNDEF_HI);
        send_pair(32'hdead_beef, 32'h0000_0000);

        for (p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 28 : (p == 1) ? 46 : 0;
            recv_idle_pct = (p == 0) ? 46 : (p == 1) ? 28 : 0;
            for (b = 0; b < 8; b++)
            begin
                set_blend_mode(mode_order[(b + 3 * p) % 8]);
                for (i = 0; i < BLOCK_ITEMS; i++)
                    send_pair(pick_pixel(), pick_pixel());
            end
        end

        wait_drain();
        repeat (8) @(negedge clk);
        $display("sent %0d pixel pairs over all eight mode values, %0d results checked,",
                 pairs_sent, results_seen);
        $display("under three stall profiles; %0d mismatches, %0d results outstanding",
                 fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
